[hdl/dsp_pkg.sv]
`default_nettype none

package dsp_pkg;

	localparam int unsigned NUM_BUTTONS = 3;
	localparam int unsigned BTN_MODE    = 0;
	localparam int unsigned BTN_UP      = 1;
	localparam int unsigned BTN_DOWN    = 2;

	typedef enum logic [1:0] {
		REG_MODE_HOLD   = 2'd0,
		REG_UP_HOLD     = 2'd1,
		REG_DOWN_HOLD   = 2'd2,
		REG_READ_PERIOD = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_PASS = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		SHOW_SETPOINT = 2'd0,
		SHOW_DIGITS   = 2'd1,
		SHOW_DOT      = 2'd2,
		SHOW_CELSIUS  = 2'd3
	} show_t;

	localparam logic [2:0] PHASE_DOT     = 3'd3;
	localparam logic [2:0] PHASE_CELSIUS = 3'd4;
	localparam logic [2:0] PHASE_FIRST   = 3'd0;

	localparam logic [7:0] MODE_HOLD_RST   = 8'h20;
	localparam logic [7:0] UP_HOLD_RST     = 8'h10;
	localparam logic [7:0] DOWN_HOLD_RST   = 8'h10;
	localparam logic [7:0] READ_PERIOD_RST = 8'd122;
	localparam logic [7:0] SETPOINT_RST    = 8'd23;

	typedef struct packed {
		logic [7:0] start;
		logic       latched;
		logic       fire;
	} btn_state_t;

endpackage

`default_nettype wire

[hdl/debounced_setpoint_panel_top.sv]
`default_nettype none

// Button panel controller: each input transfer is a timer tick or a control pass that samples
// the mode, up and down buttons (active low). Every input transfer gives exactly one result
// transfer, registered in the cycle after it; the internal state is updated in the same cycle,
// so the block takes one item per cycle while the output register drains. Hold times and the
// sensor read period are written through the configuration port; the user must write them
// only while the block is idle, and the block itself does not enforce this.
module debounced_setpoint_panel_top
	import dsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [0] mode_level, [1] up_level, [2] down_level
	input  wire logic        s_axis_tuser,   // [0] opcode

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata    // [7:0] setpoint, [8] set_mode,
	                                         // [9] read_request, [11:10] show_what
);

	logic [7:0] hold_q [NUM_BUTTONS];
	logic [7:0] period_ticks_q;

	logic [7:0] clock_q [NUM_BUTTONS];
	logic [7:0] start_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] latched_q;
	logic       mode_q;
	logic [7:0] temp_q;
	logic [7:0] period_q;
	logic [2:0] phase_q;

	logic [7:0] clock_d [NUM_BUTTONS];
	logic [7:0] start_d [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] latched_d;
	logic       mode_d;
	logic [7:0] temp_d;
	logic [7:0] period_d;
	logic [2:0] phase_d;
	logic       req_d;
	show_t      show_d;

	logic       in_xfer;
	logic       is_pass;
	logic [2:0] levels;
	btn_state_t btn [NUM_BUTTONS];

	function automatic btn_state_t debounce(
		input logic       level,
		input logic [7:0] clock,
		input logic [7:0] start,
		input logic       latched,
		input logic [7:0] hold
	);
		btn_state_t r;
		logic [7:0] elapsed;
		r.start   = start;
		r.latched = latched;
		r.fire    = 1'b0;
		elapsed   = clock - start;
		if (!level) begin
			if (!latched) begin
				if (start == 8'd0) begin
					r.start = clock;
				end else if (elapsed >= hold) begin
					r.latched = 1'b1;
				end
			end
		end else begin
			r.fire    = latched;
			r.start   = 8'd0;
			r.latched = 1'b0;
		end
		return r;
	endfunction

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign is_pass       = (opcode_t'(s_axis_tuser) == OP_PASS);
	assign levels        = s_axis_tdata[2:0];

	always_comb begin
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			clock_d[b]   = clock_q[b];
			start_d[b]   = start_q[b];
			latched_d[b] = latched_q[b];
			btn[b] = debounce(levels[b], clock_q[b], start_q[b], latched_q[b], hold_q[b]);
		end
		mode_d   = mode_q;
		temp_d   = temp_q;
		period_d = period_q;
		phase_d  = phase_q;
		req_d    = 1'b0;
		show_d   = SHOW_SETPOINT;

		if (!is_pass) begin
			period_d = period_q + 8'd1;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				clock_d[b] = clock_q[b] + 8'd1;
			end
		end else begin
			start_d[BTN_MODE]   = btn[BTN_MODE].start;
			latched_d[BTN_MODE] = btn[BTN_MODE].latched;
			mode_d              = mode_q ^ btn[BTN_MODE].fire;
			if (mode_d) begin
				start_d[BTN_UP]     = btn[BTN_UP].start;
				latched_d[BTN_UP]   = btn[BTN_UP].latched;
				start_d[BTN_DOWN]   = btn[BTN_DOWN].start;
				latched_d[BTN_DOWN] = btn[BTN_DOWN].latched;
				temp_d = temp_q + {7'd0, btn[BTN_UP].fire} - {7'd0, btn[BTN_DOWN].fire};
			end else begin
				if (period_q >= period_ticks_q) begin
					req_d    = 1'b1;
					period_d = 8'd0;
				end
				if (phase_q == PHASE_DOT) begin
					show_d  = SHOW_DOT;
					phase_d = PHASE_CELSIUS;
				end else if (phase_q == PHASE_CELSIUS) begin
					show_d  = SHOW_CELSIUS;
					phase_d = PHASE_FIRST;
				end else begin
					show_d  = SHOW_DIGITS;
					phase_d = phase_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q[BTN_MODE] <= MODE_HOLD_RST;
			hold_q[BTN_UP]   <= UP_HOLD_RST;
			hold_q[BTN_DOWN] <= DOWN_HOLD_RST;
			period_ticks_q   <= READ_PERIOD_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_MODE_HOLD:   hold_q[BTN_MODE] <= cfg_data;
				REG_UP_HOLD:     hold_q[BTN_UP]   <= cfg_data;
				REG_DOWN_HOLD:   hold_q[BTN_DOWN] <= cfg_data;
				REG_READ_PERIOD: period_ticks_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				clock_q[b] <= 8'd0;
				start_q[b] <= 8'd0;
			end
			latched_q <= '0;
			mode_q    <= 1'b0;
			temp_q    <= SETPOINT_RST;
			period_q  <= 8'd0;
			phase_q   <= PHASE_FIRST;
		end else if (in_xfer) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				clock_q[b] <= clock_d[b];
				start_q[b] <= start_d[b];
			end
			latched_q <= latched_d;
			mode_q    <= mode_d;
			temp_q    <= temp_d;
			period_q  <= period_d;
			phase_q   <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_axis_tdata <= {4'd0, show_d, req_d, mode_d, temp_d};
		end
	end

	a_latch_has_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q[BTN_MODE] |-> (start_q[BTN_MODE] != 8'd0))
		else $error("mode button latched without a start stamp");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == 3'd0) || (phase_q == 3'd1) || (phase_q == 3'd2) ||
		(phase_q == PHASE_DOT) || (phase_q == PHASE_CELSIUS))
		else $error("display phase out of sequence");

	a_show_display_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[11:10] != SHOW_SETPOINT)) |-> !m_axis_tdata[8])
		else $error("display step shown in set mode");

	a_req_display_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[9]) |-> (m_axis_tdata[11:10] != SHOW_SETPOINT))
		else $error("read request outside a display pass");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> m_axis_tvalid)
		else $error("input transfer produced no result");

	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !is_pass) |=> (m_axis_tdata[11:9] == 3'd0))
		else $error("tick produced a request or display step");

endmodule

`default_nettype wire
